// File: design/mhpf_pkg.sv
// Shared types and constants for the 802.15.4 MAC header parser and filter.
// Used by the channel interfaces and by mac_header_parse_filter_core.
`default_nettype none

package mhpf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PAN_ID        = 3'd0;
  localparam logic [2:0] CFG_OWN_SHORT     = 3'd1;
  localparam logic [2:0] CFG_OWN_EXTENDED  = 3'd2;
  localparam logic [2:0] CFG_PROMISCUOUS   = 3'd3;
  localparam logic [2:0] CFG_AUTO_ACK      = 3'd4;
  localparam logic [2:0] CFG_PAN_COORD     = 3'd5;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 64;

  // Reset values of the configuration registers.
  localparam logic [15:0] PAN_ID_RESET    = 16'hffff;
  localparam logic [15:0] OWN_SHORT_RESET = 16'hffff;
  localparam logic [63:0] OWN_EXT_RESET   = 64'h0;

  localparam logic [15:0] BCAST_SHORT = 16'hffff;
  localparam logic [63:0] BCAST_EXT   = 64'hffff_ffff_ffff_ffff;

  // Address modes.
  localparam logic [1:0] ADDR_SHORT = 2'd2;
  localparam logic [1:0] ADDR_EXT   = 2'd3;

  // Frame types.
  localparam logic [2:0] FT_BEACON = 3'd0;
  localparam logic [2:0] FT_DATA   = 3'd1;
  localparam logic [2:0] FT_CMD    = 3'd3;
  localparam logic [2:0] FT_MAX    = 3'd3;
  localparam logic [1:0] VER_MAX   = 2'd1;

  typedef enum logic [2:0] {
    V_ACCEPT     = 3'd0,
    V_BAD_TYPE   = 3'd1,
    V_BAD_VER    = 3'd2,
    V_DEST_PAN   = 3'd3,
    V_DEST_ADDR  = 3'd4,
    V_BEACON_PAN = 3'd5,
    V_SRC_PAN    = 3'd6,
    V_NO_DEST    = 3'd7
  } verdict_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [2:0] frame_kind;
    logic [7:0] sequence_number;
    logic       send_ack;
    logic [4:0] header_length;
  } out_res_t;

  // Destination field bytes (PAN plus address) for a frame control word.
  function automatic logic [3:0] dest_bytes(input logic [15:0] fcf);
    logic [3:0] n;
    case (fcf[11:10])
      ADDR_SHORT: n = 4'd4;
      ADDR_EXT:   n = 4'd10;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  // Source PAN bytes: present only with a source address and no compression.
  function automatic logic [1:0] src_pan_bytes(input logic [15:0] fcf);
    logic [1:0] n;
    n = (fcf[15] && !fcf[6]) ? 2'd2 : 2'd0;
    return n;
  endfunction

  function automatic logic [3:0] src_addr_bytes(input logic [15:0] fcf);
    logic [3:0] n;
    case (fcf[15:14])
      ADDR_SHORT: n = 4'd2;
      ADDR_EXT:   n = 4'd8;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/mhpf_in_if.sv
// Request channel carrying received frame bytes into the header filter.
// Depends on mhpf_pkg for the payload type.
`default_nettype none

interface mhpf_in_if
  import mhpf_pkg::*;
();
  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/mhpf_out_if.sv
// Result channel carrying one filter verdict per parsed header.
// Depends on mhpf_pkg for the payload type.
`default_nettype none

interface mhpf_out_if
  import mhpf_pkg::*;
();
  logic     valid;
  logic     ready;
  out_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/mac_header_parse_filter_core.sv
// Top level of the 802.15.4 MAC header parser and receive filter.
// Depends on mhpf_pkg, mhpf_in_if and mhpf_out_if.
`default_nettype none

//  Channel   Direction  Carries
//  in_req    sink       one frame byte per request, with a frame start flag
//  out_res   source     one verdict request at the end of each frame header
//  cfg_*     input      plain register writes, no read-back
//
//  A byte is held in an input register, then the parse and filter logic
//  updates the header state and loads the result register.
//  With out_res ready held high, one byte is taken every cycle; the last header
//  byte passes through the input and result registers before the verdict is valid.
//  A pending result that is not taken holds the input register and the header
//  state; reset (rst_n low, synchronous) empties both registers and ends any open frame.

module mac_header_parse_filter_core
  import mhpf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  mhpf_in_if.sink                       in_req,
  mhpf_out_if.source                    out_res,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_wdata
);

  // Configuration registers.
  logic [15:0] pan_id_r;
  logic [15:0] own_short_r;
  logic [63:0] own_ext_r;
  logic        promiscuous_r;
  logic        auto_ack_r;
  logic        pan_coord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_id_r      <= PAN_ID_RESET;
      own_short_r   <= OWN_SHORT_RESET;
      own_ext_r     <= OWN_EXT_RESET;
      promiscuous_r <= 1'b0;
      auto_ack_r    <= 1'b1;
      pan_coord_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAN_ID:       pan_id_r      <= cfg_wdata[15:0];
        CFG_OWN_SHORT:    own_short_r   <= cfg_wdata[15:0];
        CFG_OWN_EXTENDED: own_ext_r     <= cfg_wdata;
        CFG_PROMISCUOUS:  promiscuous_r <= cfg_wdata[0];
        CFG_AUTO_ACK:     auto_ack_r    <= cfg_wdata[0];
        CFG_PAN_COORD:    pan_coord_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register and handshake. The input register drains whenever the
  // result register is empty or being read, so a result waiting at the
  // output holds the byte in the input register; an empty one still captures a byte.
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_req_t  s1_data_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  out_res_t out_data_r;
  logic     advance;
  logic     fire;
  logic     in_take;

  assign advance      = !out_valid_r || out_res.ready;
  assign fire         = s1_valid_r && advance;
  assign in_req.ready = !s1_valid_r || advance;
  assign in_take      = in_req.valid && in_req.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_req.data;
    end
  end

  // Header state. The field registers are cleared logically by a frame
  // start, so they carry no reset of their own.
  logic        active_r;
  logic [4:0]  pos_r;
  logic [15:0] cw_r;
  logic [7:0]  seq_r;
  logic [15:0] dpan_r;
  logic [63:0] daddr_r;
  logic [15:0] span_r;

  // Values seen by the current byte: a frame start restarts from zero.
  logic        start;
  logic        act;
  logic [7:0]  rx;
  logic [4:0]  pos;
  logic [15:0] cw_cur;
  logic [7:0]  seq_cur;
  logic [15:0] dpan_cur;
  logic [63:0] daddr_cur;
  logic [15:0] span_cur;

  assign start     = s1_data_r.frame_start;
  assign act       = start || active_r;
  assign rx        = s1_data_r.rx_byte;
  assign pos       = start ? 5'd0  : pos_r;
  assign cw_cur    = start ? 16'd0 : cw_r;
  assign seq_cur   = start ? 8'd0  : seq_r;
  assign dpan_cur  = start ? 16'd0 : dpan_r;
  assign daddr_cur = start ? 64'd0 : daddr_r;
  assign span_cur  = start ? 16'd0 : span_r;

  // Field lengths follow the full frame control word, which is complete
  // by the time the sequence number byte arrives.
  logic [3:0]  dlen;
  logic [1:0]  spl;
  logic [3:0]  sal;
  logic [4:0]  dest_end;
  logic [4:0]  span_end;
  logic [4:0]  hlen;
  logic [4:0]  k_dest;
  logic [4:0]  k_addr;
  logic [4:0]  k_span;

  assign dlen     = dest_bytes(cw_cur);
  assign spl      = src_pan_bytes(cw_cur);
  assign sal      = src_addr_bytes(cw_cur);
  assign dest_end = 5'd3 + {1'b0, dlen};
  assign span_end = dest_end + {3'd0, spl};
  assign hlen     = span_end + {1'b0, sal};
  assign k_dest   = pos - 5'd3;
  assign k_addr   = k_dest - 5'd2;
  assign k_span   = pos - dest_end;

  logic [15:0] cw_new;
  logic [7:0]  seq_new;
  logic [15:0] dpan_new;
  logic [63:0] daddr_new;
  logic [15:0] span_new;
  logic        done;

  always_comb begin
    cw_new    = cw_cur;
    seq_new   = seq_cur;
    dpan_new  = dpan_cur;
    daddr_new = daddr_cur;
    span_new  = span_cur;
    done      = 1'b0;
    if (pos == 5'd0) begin
      cw_new = {8'd0, rx};
    end else if (pos == 5'd1) begin
      cw_new = {rx, cw_cur[7:0]};
    end else begin
      if (pos == 5'd2) begin
        seq_new = rx;
      end else if (pos < dest_end) begin
        if (k_dest < 5'd2) begin
          if (k_dest[0]) begin
            dpan_new[15:8] = rx;
          end else begin
            dpan_new[7:0] = rx;
          end
        end else begin
          daddr_new = daddr_cur | ({56'd0, rx} << {k_addr[2:0], 3'b000});
        end
      end else if (pos < span_end) begin
        if (k_span[0]) begin
          span_new[15:8] = rx;
        end else begin
          span_new[7:0] = rx;
        end
      end
      // The last header byte is the one whose position reaches hlen - 1.
      done = act && ({1'b0, pos} + 6'd1 >= {1'b0, hlen});
    end
  end

  // Filter rules in verdict order, but V_NO_DEST before V_SRC_PAN; the first that fails wins.
  // A compressed source PAN is taken from the destination PAN.
  logic [15:0] span_j;
  logic [2:0]  ftype;
  logic [1:0]  dmode;
  verdict_t    verdict;
  logic        send_ack;

  assign span_j = cw_new[6] ? dpan_new : span_new;
  assign ftype  = cw_new[2:0];
  assign dmode  = cw_new[11:10];

  always_comb begin
    verdict = V_ACCEPT;
    if (promiscuous_r) begin
      verdict = V_ACCEPT;
    end else if (ftype > FT_MAX) begin
      verdict = V_BAD_TYPE;
    end else if (cw_new[13:12] > VER_MAX) begin
      verdict = V_BAD_VER;
    end else if (dmode[1] && dpan_new != pan_id_r && dpan_new != BCAST_SHORT) begin
      verdict = V_DEST_PAN;
    end else if (dmode == ADDR_SHORT && daddr_new[15:0] != own_short_r &&
                 daddr_new[15:0] != BCAST_SHORT) begin
      verdict = V_DEST_ADDR;
    end else if (dmode == ADDR_EXT && daddr_new != own_ext_r &&
                 daddr_new != BCAST_EXT) begin
      verdict = V_DEST_ADDR;
    end else if (ftype == FT_BEACON && pan_id_r != BCAST_SHORT && span_j != pan_id_r) begin
      verdict = V_BEACON_PAN;
    end else if ((ftype == FT_DATA || ftype == FT_CMD) && !dmode[1]) begin
      if (!pan_coord_r) begin
        verdict = V_NO_DEST;
      end else if (span_j != pan_id_r) begin
        verdict = V_SRC_PAN;
      end
    end
  end

  assign send_ack = !promiscuous_r && (verdict == V_ACCEPT) && cw_new[5] && auto_ack_r;

  // State update, once per byte of an open frame leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= 5'd0;
    end else if (fire && act) begin
      if (done) begin
        active_r <= 1'b0;
        pos_r    <= 5'd0;
      end else begin
        active_r <= 1'b1;
        pos_r    <= pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && act) begin
      cw_r    <= cw_new;
      seq_r   <= seq_new;
      dpan_r  <= dpan_new;
      daddr_r <= daddr_new;
      span_r  <= span_new;
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && done) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && done) begin
      out_data_r.verdict         <= verdict;
      out_data_r.frame_kind      <= ftype;
      out_data_r.sequence_number <= seq_new;
      out_data_r.send_ack        <= send_ack;
      out_data_r.header_length   <= hlen;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for mac_header_parse_filter_core, the 802.15.4 header filter.
// Depends on mhpf_pkg, mhpf_in_if, mhpf_out_if and the core itself; reads no files.
// Directed frames come first, then random traffic under four handshake pacing modes.

module tb;
  import mhpf_pkg::*;

  // Frame control encodings that the package does not name.
  localparam logic [1:0]  ADDR_NONE     = 2'd0;
  localparam logic [1:0]  ADDR_RSVD     = 2'd1;
  localparam logic [2:0]  FT_ACK        = 3'd2;
  localparam logic [2:0]  FT_RSVD       = 3'd7;
  localparam logic [1:0]  VER_2003      = 2'd0;
  localparam logic [1:0]  VER_2006      = 2'd1;
  localparam logic [1:0]  VER_RSVD      = 2'd3;
  // Security, frame pending and the reserved bits 7..9 do not affect filtering.
  localparam logic [15:0] FC_SPARE_BITS = 16'h0398;

  // The verdict follows the last byte through the input and result registers; margin on top.
  localparam int SETTLE_CYCLES = 4;
  // Cycles without any accepted request before the run is declared hung.
  localparam int QUIET_LIMIT   = 2000;
  localparam int BYTES_PER_PHASE = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_wdata;

  mhpf_in_if  in_req ();
  mhpf_out_if out_res ();

  mac_header_parse_filter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the filter registers, starting at their reset values.
  logic [15:0] cfg_pan      = PAN_ID_RESET;
  logic [15:0] cfg_short    = OWN_SHORT_RESET;
  logic [63:0] cfg_ext      = OWN_EXT_RESET;
  logic        cfg_prom     = 1'b0;
  logic        cfg_auto_ack = 1'b1;
  logic        cfg_coord    = 1'b0;

  // Header parse state of the predictor.
  logic [4:0]  hdr_pos  = '0;
  logic        in_frame = 1'b0;
  logic [15:0] fc_word  = '0;
  logic [7:0]  seq_byte = '0;
  logic [15:0] dst_pan  = '0;
  logic [63:0] dst_addr = '0;
  logic [15:0] src_pan  = '0;

  // Verdicts predicted but not yet seen on the result channel, oldest first.
  out_res_t verdict_q[$];
  out_res_t got_res, want_res;

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors = 0;
  int parsed_bytes = 0;
  int verdicts_checked = 0;
  int accepted_frames = 0;
  int acks_seen = 0;
  int config_sets = 0;
  int quiet_cycles = 0;

  // Lengths of the variable header fields for a given frame control word.
  function automatic int dest_field_len(input logic [15:0] fc);
    case (fc[11:10])
      ADDR_SHORT: return 4;
      ADDR_EXT:   return 10;
      default:    return 0;
    endcase
  endfunction

  function automatic int src_pan_len(input logic [15:0] fc);
    return (fc[15:14] >= ADDR_SHORT && !fc[6]) ? 2 : 0;
  endfunction

  function automatic int src_addr_len(input logic [15:0] fc);
    case (fc[15:14])
      ADDR_SHORT: return 2;
      ADDR_EXT:   return 8;
      default:    return 0;
    endcase
  endfunction

  function automatic logic [15:0] frame_control(input logic [2:0] ft, input logic [1:0] dm,
                                                input logic [1:0] sm, input logic ack_req,
                                                input logic comp, input logic [1:0] ver);
    return {sm, ver, dm, 3'b000, comp, ack_req, 2'b00, ft};
  endfunction

  // Filter rules are tried in verdict order, but V_NO_DEST before V_SRC_PAN; the first failing rule wins.
  function automatic verdict_t filter_verdict();
    logic [2:0] ft;
    logic [1:0] dm;
    ft = fc_word[2:0];
    dm = fc_word[11:10];
    if (ft > FT_MAX) return V_BAD_TYPE;
    if (fc_word[13:12] > VER_MAX) return V_BAD_VER;
    if (dm >= ADDR_SHORT && dst_pan != cfg_pan && dst_pan != BCAST_SHORT) return V_DEST_PAN;
    if (dm == ADDR_SHORT && dst_addr[15:0] != cfg_short && dst_addr[15:0] != BCAST_SHORT)
      return V_DEST_ADDR;
    if (dm == ADDR_EXT && dst_addr != cfg_ext && dst_addr != BCAST_EXT) return V_DEST_ADDR;
    // A beacon only has to match when this device has joined a PAN.
    if (ft == FT_BEACON && cfg_pan != BCAST_SHORT && src_pan != cfg_pan) return V_BEACON_PAN;
    if ((ft == FT_DATA || ft == FT_CMD) && dm < ADDR_SHORT) begin
      if (!cfg_coord) return V_NO_DEST;
      if (src_pan != cfg_pan) return V_SRC_PAN;
    end
    return V_ACCEPT;
  endfunction

  // Advances the predicted parser by one accepted byte. Returns one when the byte
  // completes a header, with the expected verdict request in res.
  function automatic bit parse_rx_byte(input logic [7:0] b, input logic start,
                                       output out_res_t res);
    int dlen, splen, hlen, k;
    res = '0;
    if (start) begin
      // A new start flag drops any partial header.
      hdr_pos  = '0;
      in_frame = 1'b1;
      fc_word  = '0;
      seq_byte = '0;
      dst_pan  = '0;
      dst_addr = '0;
      src_pan  = '0;
    end
    if (!in_frame) return 1'b0;
    if (hdr_pos == 0) begin
      fc_word = {8'h00, b};
    end else if (hdr_pos == 1) begin
      fc_word[15:8] = b;
    end else begin
      dlen  = dest_field_len(fc_word);
      splen = src_pan_len(fc_word);
      if (hdr_pos == 2) begin
        seq_byte = b;
      end else if (hdr_pos < 3 + dlen) begin
        k = hdr_pos - 3;
        if (k < 2) dst_pan[8*k +: 8] = b;
        else dst_addr[8*(k-2) +: 8] = b;
      end else if (hdr_pos < 3 + dlen + splen) begin
        k = (hdr_pos - 3 - dlen) & 1;
        src_pan[8*k +: 8] = b;
      end
      // Source address bytes are only counted.
      hlen = 3 + dlen + splen + src_addr_len(fc_word);
      if (hdr_pos + 1 >= hlen) begin
        // With PAN ID compression the source PAN is the destination PAN.
        if (fc_word[6]) src_pan = dst_pan;
        if (cfg_prom) begin
          res.verdict  = V_ACCEPT;
          res.send_ack = 1'b0;
        end else begin
          res.verdict  = filter_verdict();
          res.send_ack = (res.verdict == V_ACCEPT) && fc_word[5] && cfg_auto_ack;
        end
        res.frame_kind      = fc_word[2:0];
        res.sequence_number = seq_byte;
        res.header_length   = 5'(hlen);
        in_frame = 1'b0;
        hdr_pos  = '0;
        return 1'b1;
      end
    end
    hdr_pos = hdr_pos + 5'd1;
    return 1'b0;
  endfunction

  // Sends one byte request, with random idle cycles in front of it, and records
  // the expected verdict when the byte closes a header.
  task automatic send_byte(input logic [7:0] b, input logic start);
    out_res_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= '{rx_byte: b, frame_start: start};
    do @(posedge clk); while (!in_req.ready);
    if (start || in_frame) parsed_bytes++;
    if (parse_rx_byte(b, start, res)) verdict_q.push_back(res);
  endtask

  // Serializes a header low byte first. A nonzero cut shorter than the header sends only
  // that many header bytes; tail adds payload bytes, which the filter ignores.
  task automatic send_frame(input logic [15:0] fc, input logic [7:0] seq,
                            input logic [15:0] dpan_v, input logic [63:0] daddr_v,
                            input logic [15:0] span_v, input logic [63:0] saddr_v,
                            input int cut, input int tail);
    logic [7:0] hdr[$];
    int i;
    hdr = {fc[7:0], fc[15:8], seq};
    if (dest_field_len(fc) != 0) begin
      hdr.push_back(dpan_v[7:0]);
      hdr.push_back(dpan_v[15:8]);
      for (i = 0; i < dest_field_len(fc) - 2; i++) hdr.push_back(daddr_v[8*i +: 8]);
    end
    if (src_pan_len(fc) != 0) begin
      hdr.push_back(span_v[7:0]);
      hdr.push_back(span_v[15:8]);
    end
    for (i = 0; i < src_addr_len(fc); i++) hdr.push_back(saddr_v[8*i +: 8]);
    if (cut > 0 && cut < hdr.size()) hdr = hdr[0:cut-1];
    foreach (hdr[j]) send_byte(hdr[j], j == 0);
    repeat (tail) send_byte(8'($urandom), 1'b0);
  endtask

  // Pads an open header with random bytes until its verdict is due.
  task automatic close_frame();
    while (in_frame) send_byte(8'($urandom), 1'b0);
  endtask

  // Waits until every predicted verdict has been seen and the core has gone quiet.
  task automatic drain();
    in_req.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIndexWidth-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Writes all six filter registers while the core is idle and mirrors them.
  task automatic apply_config(input logic [15:0] pan, input logic [15:0] short_addr,
                              input logic [63:0] ext_addr, input logic prom,
                              input logic auto_ack, input logic coord);
    drain();
    cfg_write(CFG_PAN_ID, {48'h0, pan});
    cfg_write(CFG_OWN_SHORT, {48'h0, short_addr});
    cfg_write(CFG_OWN_EXTENDED, ext_addr);
    cfg_write(CFG_PROMISCUOUS, {63'h0, prom});
    cfg_write(CFG_AUTO_ACK, {63'h0, auto_ack});
    cfg_write(CFG_PAN_COORD, {63'h0, coord});
    cfg_we       <= 1'b0;
    cfg_pan      = pan;
    cfg_short    = short_addr;
    cfg_ext      = ext_addr;
    cfg_prom     = prom;
    cfg_auto_ack = auto_ack;
    cfg_coord    = coord;
    config_sets++;
  endtask

  // Reset register values: no PAN joined, broadcast short address, extended
  // address zero, auto ack on. Covers the shortest header and both byte extremes.
  task automatic test_reset_defaults();
    send_frame(frame_control(FT_ACK, ADDR_NONE, ADDR_NONE, 1'b1, 1'b0, VER_2003),
               8'h00, '0, '0, '0, '0, 0, 0);
    send_frame(frame_control(FT_DATA, ADDR_SHORT, ADDR_SHORT, 1'b1, 1'b1, VER_2006),
               8'hff, BCAST_SHORT, 64'hffff, '0, 64'h00ff, 0, 0);
    send_frame(frame_control(FT_CMD, ADDR_EXT, ADDR_NONE, 1'b0, 1'b0, VER_2006),
               8'h5a, BCAST_SHORT, OWN_EXT_RESET, '0, '0, 0, 0);
  endtask

  // Frames for each rejection rule but the source PAN one, plus the broadcast and compressed-PAN passes.
  task automatic test_filter_rules();
    apply_config(16'h0000, 16'h0000, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 1'b0);
    send_frame(frame_control(FT_RSVD, ADDR_NONE, ADDR_NONE, 1'b0, 1'b0, VER_2003),
               8'h01, '0, '0, '0, '0, 0, 0);
    send_frame(frame_control(FT_DATA, ADDR_NONE, ADDR_NONE, 1'b0, 1'b0, VER_RSVD),
               8'h02, '0, '0, '0, '0, 0, 0);
    send_frame(frame_control(FT_DATA, ADDR_SHORT, ADDR_NONE, 1'b0, 1'b0, VER_2003),
               8'h03, 16'h1234, 64'h0, '0, '0, 0, 0);
    send_frame(frame_control(FT_DATA, ADDR_SHORT, ADDR_NONE, 1'b0, 1'b0, VER_2003),
               8'h04, 16'h0000, 64'h0001, '0, '0, 0, 0);
    send_frame(frame_control(FT_CMD, ADDR_EXT, ADDR_NONE, 1'b0, 1'b0, VER_2006),
               8'h05, BCAST_SHORT, 64'h0123_4567_89ab_cdef, '0, '0, 0, 0);
    // Extended broadcast is accepted, but auto ack is off here.
    send_frame(frame_control(FT_DATA, ADDR_EXT, ADDR_NONE, 1'b1, 1'b0, VER_2006),
               8'h06, 16'h0000, BCAST_EXT, '0, '0, 0, 0);
    send_frame(frame_control(FT_BEACON, ADDR_NONE, ADDR_SHORT, 1'b0, 1'b0, VER_2003),
               8'h07, '0, '0, 16'h5555, 64'h7777, 0, 0);
    // Compressed source PAN is taken from the destination PAN, so this beacon passes.
    send_frame(frame_control(FT_BEACON, ADDR_SHORT, ADDR_SHORT, 1'b0, 1'b1, VER_2003),
               8'h08, 16'h0000, 64'h0000, 16'h5555, 64'h9999, 0, 0);
    send_frame(frame_control(FT_DATA, ADDR_NONE, ADDR_SHORT, 1'b0, 1'b0, VER_2003),
               8'h09, '0, '0, 16'h0000, 64'h1111, 0, 0);
    // Reserved destination mode counts as no destination and adds no bytes.
    send_frame(frame_control(FT_DATA, ADDR_RSVD, ADDR_RSVD, 1'b0, 1'b0, VER_2003),
               8'h0a, '0, '0, '0, '0, 0, 0);
  endtask

  // Frames without a destination as seen by a PAN coordinator, plus the longest header.
  task automatic test_coordinator();
    apply_config(16'habcd, 16'h00a5, 64'hfedc_ba98_7654_3210, 1'b0, 1'b1, 1'b1);
    send_frame(frame_control(FT_DATA, ADDR_NONE, ADDR_SHORT, 1'b1, 1'b0, VER_2006),
               8'h10, '0, '0, 16'habcd, 64'h2222, 0, 0);
    send_frame(frame_control(FT_DATA, ADDR_NONE, ADDR_EXT, 1'b1, 1'b0, VER_2006),
               8'h11, '0, '0, 16'h1111, 64'h3333_4444_5555_6666, 0, 0);
    // No source PAN at all leaves it at zero, which does not match.
    send_frame(frame_control(FT_CMD, ADDR_NONE, ADDR_NONE, 1'b0, 1'b0, VER_2003),
               8'h12, '0, '0, '0, '0, 0, 0);
    // Longest header: extended addresses on both sides with a source PAN.
    send_frame(frame_control(FT_DATA, ADDR_EXT, ADDR_EXT, 1'b1, 1'b0, VER_2006),
               8'h13, 16'habcd, 64'hfedc_ba98_7654_3210, 16'h0000, '1, 0, 0);
    // Compression without a destination copies a zero source PAN.
    send_frame(frame_control(FT_BEACON, ADDR_NONE, ADDR_SHORT, 1'b0, 1'b1, VER_2003),
               8'h14, '0, '0, 16'habcd, 64'h4444, 0, 0);
  endtask

  // Bytes outside a frame, a restart in the middle of a header, and payload.
  task automatic test_framing();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_frame(frame_control(FT_DATA, ADDR_SHORT, ADDR_SHORT, 1'b1, 1'b1, VER_2006),
               8'h20, 16'habcd, 64'h00a5, '0, 64'h5555, 5, 0);
    send_frame(frame_control(FT_DATA, ADDR_SHORT, ADDR_SHORT, 1'b1, 1'b1, VER_2006),
               8'h21, 16'habcd, 64'h00a5, '0, 64'h5555, 0, 4);
  endtask

  // Promiscuous mode passes even a reserved type and never asks for an ack.
  task automatic test_promiscuous();
    apply_config(16'h0001, 16'hfffe, 64'h0, 1'b1, 1'b1, 1'b0);
    send_frame(frame_control(FT_RSVD, ADDR_NONE, ADDR_NONE, 1'b1, 1'b0, VER_RSVD),
               8'h30, '0, '0, '0, '0, 0, 0);
    send_frame(frame_control(FT_DATA, ADDR_SHORT, ADDR_NONE, 1'b1, 1'b0, VER_2006),
               8'h31, 16'h7777, 64'h1234, '0, '0, 0, 0);
  endtask

  // A header whose addresses mostly hit the current registers, so that most
  // frames get deep into the rule chain; broken frames are cut short.
  task automatic random_frame(input bit broken);
    logic [2:0]  ft;
    logic [1:0]  dm, sm, ver;
    logic [15:0] fc, dpan_v, span_v;
    logic [63:0] daddr_v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) ft = FT_DATA;
    else if (pick < 60) ft = FT_CMD;
    else if (pick < 80) ft = FT_BEACON;
    else if (pick < 90) ft = FT_ACK;
    else ft = 3'($urandom_range(4, 7));
    ver = ($urandom_range(9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
    dm  = 2'($urandom_range(3));
    sm  = 2'($urandom_range(3));
    fc  = frame_control(ft, dm, sm, 1'($urandom_range(1)), 1'($urandom_range(1)), ver)
          | (16'($urandom) & FC_SPARE_BITS);
    daddr_v = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 50) begin
      if (dm == ADDR_EXT) daddr_v = cfg_ext;
      else daddr_v[15:0] = cfg_short;
    end else if (pick < 75) begin
      daddr_v = BCAST_EXT;
    end
    pick = $urandom_range(99);
    dpan_v = (pick < 60) ? cfg_pan : (pick < 80) ? BCAST_SHORT : 16'($urandom);
    span_v = ($urandom_range(99) < 60) ? cfg_pan : 16'($urandom);
    send_frame(fc, 8'($urandom), dpan_v, daddr_v, span_v, {$urandom, $urandom},
               broken ? $urandom_range(1, 22) : 0, broken ? 0 : $urandom_range(3));
  endtask

  // One pacing mode with its own register setting: mostly clean frames, some
  // truncated ones and some loose bytes with an occasional start flag.
  task automatic test_random_traffic(input int phase);
    int first;
    int pick;
    case (phase)
      0: apply_config(16'($urandom), 16'($urandom), {$urandom, $urandom}, 1'b0, 1'b1, 1'b1);
      1: apply_config(16'($urandom), 16'hffff, BCAST_EXT, 1'b0, 1'b0, 1'b0);
      2: apply_config(PAN_ID_RESET, 16'($urandom), {$urandom, $urandom}, 1'b0, 1'b1, 1'b1);
      default: apply_config(16'($urandom), 16'($urandom), 64'h0, 1'($urandom_range(1)),
                            1'b1, 1'b0);
    endcase
    case (phase)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 65; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 65; end
      default: begin idle_pct = 20; stall_pct = 20; end
    endcase
    first = parsed_bytes;
    while (parsed_bytes - first < BYTES_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 80) random_frame(1'b0);
      else if (pick < 90) random_frame(1'b1);
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(7) == 0);
    end
    close_frame();
    drain();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // The result side stalls at random according to the current pacing mode.
  always @(posedge clk) out_res.ready <= ($urandom_range(99) >= stall_pct);

  // Every verdict request taken is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      got_res = out_res.data;
      if (verdict_q.size() == 0) begin
        $error("verdict request with nothing predicted: verdict %0d seq %0d",
               got_res.verdict, got_res.sequence_number);
        errors++;
      end else begin
        want_res = verdict_q.pop_front();
        if (got_res.verdict !== want_res.verdict) begin
          $error("verdict: expected %0d, got %0d", want_res.verdict, got_res.verdict);
          errors++;
        end
        if (got_res.frame_kind !== want_res.frame_kind) begin
          $error("frame_kind: expected %0d, got %0d", want_res.frame_kind,
                 got_res.frame_kind);
          errors++;
        end
        if (got_res.sequence_number !== want_res.sequence_number) begin
          $error("sequence_number: expected %0d, got %0d", want_res.sequence_number,
                 got_res.sequence_number);
          errors++;
        end
        if (got_res.send_ack !== want_res.send_ack) begin
          $error("send_ack: expected %0d, got %0d", want_res.send_ack, got_res.send_ack);
          errors++;
        end
        if (got_res.header_length !== want_res.header_length) begin
          $error("header_length: expected %0d, got %0d", want_res.header_length,
                 got_res.header_length);
          errors++;
        end
        verdicts_checked++;
        if (want_res.verdict == V_ACCEPT) accepted_frames++;
        if (want_res.send_ack) acks_seen++;
      end
    end
  end

  // Hang detection: too long without a request moving on either channel.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No request moved for %0d cycles, %0d verdicts still due.",
               quiet_cycles, verdict_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_req.valid  = 1'b0;
    in_req.data   = '0;
    out_res.ready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_filter_rules();
    test_coordinator();
    test_framing();
    test_promiscuous();
    for (int phase = 0; phase < 4; phase++) test_random_traffic(phase);
    drain();

    $display("Checked %0d verdict requests from %0d header bytes under %0d register settings.",
             verdicts_checked, parsed_bytes, config_sets + 1);
    $display("Of these %0d were accepted and %0d asked for an ack; four pacing modes ran.",
             accepted_frames, acks_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
